// ===== design/tgl_pkg.sv =====
// Shared types and constants of the timestamp generation ledger.
// Operation, lookup and register codes, field widths and the packed word layouts.
// No dependencies.
package tgl_pkg;

	localparam int TS_W      = 64;
	localparam int GEN_W     = 64;
	localparam int STEP_W    = 63;
	localparam int CNT_OUT_W = 7;
	localparam int OP_W      = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 64;
	localparam int IN_W      = 200;
	localparam int OUT_W     = 280;

	localparam logic [TS_W-1:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR       = 3'd0,
		OP_AUTO_REC    = 3'd1,
		OP_RECORD      = 3'd2,
		OP_MARK_AMBIG  = 3'd3,
		OP_LOOKUP      = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		LK_MISSING = 2'd0,
		LK_PROVEN  = 2'd1,
		LK_AMBIG   = 2'd2
	} lookup_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STEP_SIZE = 1'b0,
		CFG_START_PTS = 1'b1
	} cfg_idx_t;

	// Input word, last declared field in the lowest bits
	typedef struct packed {
		logic [6:0]       pad;
		logic [GEN_W-1:0] pkt_emitted_gen;
		logic             pkt_has_gen;
		logic [GEN_W-1:0] generation;
		logic [TS_W-1:0]  pts;
	} in_word_t;

	// Result word, last declared field in the lowest bits
	typedef struct packed {
		logic [3:0]           pad;
		logic                 table_full;
		logic [GEN_W-1:0]     pkt_gen_out;
		logic                 pkt_ambiguous_out;
		logic                 pkt_has_gen_out;
		logic                 pkt_update;
		logic [CNT_OUT_W-1:0] amb_count;
		logic [CNT_OUT_W-1:0] entry_count;
		logic [TS_W-1:0]      stamp_next;
		logic [TS_W-1:0]      stamp_used;
		logic [GEN_W-1:0]     found_gen;
		logic [1:0]           lookup_status;
	} out_word_t;

endpackage

// ===== design/timestamp_generation_ledger.sv =====
// Timestamp generation ledger: content-addressed table of timestamp to generation.
// Linear scan of an entry memory through one shared key comparator under a sequencer.
// Depends on tgl_pkg.
//
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+---------------------------------------
// s_*      | in        | s_tvalid / s_tready | s_tuser op, s_tdata operands
// m_*      | out       | m_tvalid / m_tready | m_tdata result word
// cfg_*    | in        | cfg_we              | cfg_index register, cfg_data value
//
// Sequence: clear and unused codes go from accept straight to the apply step; automatic record,
// record, ambiguity mark and lookup first scan one entry per cycle from the entry memory read
// port, up to entry_count entries and stopping at the first match, then apply.
// The next word is accepted once the result is loaded and the block is back in idle.
// Reset: no clearing pass; the fill count marks live entries, and clear resets it.
// Stalls: a held result blocks the final table update until the output register frees;
// the next word is accepted once the block is back in idle.
module timestamp_generation_ledger #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// config write port
	input  logic                          cfg_we,
	input  logic [tgl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tgl_pkg::CFG_W-1:0]     cfg_data,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// s_tdata, low bit up: pts[63:0], generation[127:64], pkt_has_gen[128],
	// pkt_emitted_gen[192:129], zero[199:193]
	input  logic [tgl_pkg::IN_W-1:0]      s_tdata,
	// s_tuser: op[2:0]
	input  logic [tgl_pkg::OP_W-1:0]      s_tuser,
	// output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata, low bit up: lookup_status[1:0], found_gen[65:2], stamp_used[129:66],
	// stamp_next[193:130], entry_count[200:194], amb_count[207:201],
	// pkt_update[208], pkt_has_gen_out[209], pkt_ambiguous_out[210],
	// pkt_gen_out[274:211], table_full[275], zero[279:276]
	output logic [tgl_pkg::OUT_W-1:0]     m_tdata
);
	import tgl_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ACT
	} state_t;

	state_t state_q;

	// config registers
	logic [STEP_W-1:0] step_q;
	logic [TS_W-1:0]   start_q;

	// ledger state
	logic [CW-1:0]   used_q;
	logic [CW-1:0]   amb_cnt_q;
	logic [TS_W-1:0] next_q;

	// latched operation
	in_word_t        in_w;
	op_t             op_q;
	logic [TS_W-1:0] key_q;
	logic [GEN_W-1:0] gen_q;
	logic            has_gen_q;
	logic [GEN_W-1:0] emitted_q;
	logic [TS_W-1:0] lim_q;

	// scan control
	logic [CW-1:0] idx_q;
	logic [AW-1:0] cmp_idx_q;
	logic          rdv_q;
	logic          issue;
	logic          match;

	// scan outcome
	logic             hit_q;
	logic [AW-1:0]    hit_idx_q;
	logic [GEN_W-1:0] hit_gen_q;
	logic             hit_amb_q;

	// entry memories
	logic [TS_W-1:0]  pts_mem [TABLE_DEPTH];
	logic [GEN_W-1:0] gen_mem [TABLE_DEPTH];
	logic             amb_mem [TABLE_DEPTH];
	logic [TS_W-1:0]  rd_pts_q;
	logic [GEN_W-1:0] rd_gen_q;
	logic             rd_amb_q;

	// action decode
	logic             out_free;
	logic             commit;
	logic             do_ins;
	logic             ins_amb;
	logic             do_mark;
	logic             is_full;
	logic             drop;
	logic [STEP_W-1:0] step_eff;
	logic [TS_W-1:0]  next_d;
	logic [CW-1:0]    used_d;
	logic [CW-1:0]    amb_d;
	logic [CW+CNT_OUT_W-1:0] used_ext;
	logic [CW+CNT_OUT_W-1:0] amb_ext;
	out_word_t        res;
	out_word_t        out_q;
	logic             out_v_q;

	assign in_w     = in_word_t'(s_tdata);
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	// read the next live entry while the fill count allows
	assign issue = (state_q == ST_SCAN) && (idx_q < used_q);
	assign match = rdv_q && (rd_pts_q == key_q);

	assign out_free = !out_v_q || m_tready;
	assign commit   = (state_q == ST_ACT) && out_free;
	assign is_full  = (used_q == DEPTH_CNT);
	assign step_eff = (step_q == '0) ? STEP_W'(1) : step_q;

	// decide the table update and build the result word
	always_comb begin
		do_ins  = 1'b0;
		ins_amb = 1'b0;
		do_mark = 1'b0;
		drop    = 1'b0;
		next_d  = next_q;
		res     = '0;
		case (op_q)
			OP_CLEAR: begin
				next_d = start_q;
			end
			OP_AUTO_REC, OP_RECORD: begin
				if (hit_q) begin
					do_mark = (hit_gen_q != gen_q) && !hit_amb_q;
				end else if (is_full) begin
					drop = 1'b1;
				end else begin
					do_ins = 1'b1;
				end
				if (op_q == OP_AUTO_REC) begin
					res.stamp_used = next_q;
					if ($signed(next_q) <= $signed(lim_q)) begin
						next_d = next_q + {1'b0, step_eff};
					end else begin
						next_d = MAX_POS;
					end
				end
			end
			OP_MARK_AMBIG: begin
				if (hit_q) begin
					do_mark = !hit_amb_q;
				end else if (is_full) begin
					drop = 1'b1;
				end else begin
					do_ins  = 1'b1;
					ins_amb = 1'b1;
				end
			end
			OP_LOOKUP: begin
				if (hit_q) begin
					res.pkt_update = 1'b1;
					if (hit_amb_q) begin
						res.lookup_status     = LK_AMBIG;
						res.pkt_ambiguous_out = 1'b1;
					end else begin
						res.lookup_status = LK_PROVEN;
						res.found_gen     = hit_gen_q;
						if (has_gen_q && (emitted_q != hit_gen_q)) begin
							res.pkt_ambiguous_out = 1'b1;
						end else begin
							res.pkt_has_gen_out = 1'b1;
							res.pkt_gen_out     = hit_gen_q;
						end
					end
				end
			end
			default: begin
			end
		endcase
		if (op_q == OP_CLEAR) begin
			used_d = '0;
			amb_d  = '0;
		end else begin
			used_d = used_q + CW'(do_ins);
			amb_d  = amb_cnt_q + CW'(do_mark || ins_amb);
		end
		used_ext        = {{CNT_OUT_W{1'b0}}, used_d};
		amb_ext         = {{CNT_OUT_W{1'b0}}, amb_d};
		res.stamp_next  = next_d;
		res.entry_count = used_ext[CNT_OUT_W-1:0];
		res.amb_count   = amb_ext[CNT_OUT_W-1:0];
		res.table_full  = drop;
	end

	// entry memories: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (commit && do_ins) begin
			pts_mem[used_q[AW-1:0]] <= key_q;
			gen_mem[used_q[AW-1:0]] <= ins_amb ? '0 : gen_q;
		end
		if (commit && (do_ins || do_mark)) begin
			amb_mem[do_ins ? used_q[AW-1:0] : hit_idx_q] <= ins_amb || do_mark;
		end
		if (issue) begin
			rd_pts_q <= pts_mem[idx_q[AW-1:0]];
			rd_gen_q <= gen_mem[idx_q[AW-1:0]];
			rd_amb_q <= amb_mem[idx_q[AW-1:0]];
		end
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_W'(1);
			start_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_STEP_SIZE: step_q  <= cfg_data[STEP_W-1:0];
				CFG_START_PTS: start_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// operand latch, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q      <= op_t'(s_tuser);
			key_q     <= (op_t'(s_tuser) == OP_AUTO_REC) ? next_q : in_w.pts;
			gen_q     <= in_w.generation;
			has_gen_q <= in_w.pkt_has_gen;
			emitted_q <= in_w.pkt_emitted_gen;
			lim_q     <= MAX_POS - {1'b0, step_eff};
		end
		if (state_q == ST_SCAN && match) begin
			hit_idx_q <= cmp_idx_q;
			hit_gen_q <= rd_gen_q;
			hit_amb_q <= rd_amb_q;
		end
		if (commit) begin
			out_q <= res;
		end
	end

	// sequencer: accept, scan, apply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			used_q    <= '0;
			amb_cnt_q <= '0;
			next_q    <= '0;
			idx_q     <= '0;
			cmp_idx_q <= '0;
			rdv_q     <= 1'b0;
			hit_q     <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			// load a new result or drop the one taken
			if (commit) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						idx_q <= '0;
						rdv_q <= 1'b0;
						hit_q <= 1'b0;
						case (op_t'(s_tuser))
							OP_AUTO_REC, OP_RECORD, OP_MARK_AMBIG, OP_LOOKUP:
								state_q <= ST_SCAN;
							default:
								state_q <= ST_ACT;
						endcase
					end
				end
				ST_SCAN: begin
					rdv_q     <= issue;
					cmp_idx_q <= idx_q[AW-1:0];
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (match) begin
						hit_q   <= 1'b1;
						state_q <= ST_ACT;
					end else if (!issue && !rdv_q) begin
						state_q <= ST_ACT;
					end
				end
				ST_ACT: begin
					if (out_free) begin
						used_q    <= used_d;
						amb_cnt_q <= amb_d;
						next_q    <= next_d;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// fill count never passes the table size
	assert property (@(posedge clk) disable iff (!arst_n) used_q <= DEPTH_CNT)
		else $error("entry count beyond table size");

	// every ambiguous entry is a live entry
	assert property (@(posedge clk) disable iff (!arst_n) amb_cnt_q <= used_q)
		else $error("ambiguous count exceeds entry count");

	// an accepted word keeps the block busy for at least the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while busy");

	// a result is produced only from the apply step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == ST_ACT))
		else $error("result without apply step");

endmodule
